### hdl/fmcv_pkg.sv
// Shared types, constants and AES helper functions for the frame MIC verify unit.
// No dependencies; used by every other file in the block.
`default_nettype none

package fmcv_pkg;

   localparam int unsigned MIN_FRAME = 12;
   localparam int unsigned MIC_BYTES = 4;
   localparam logic [7:0]  B0_TAG    = 8'h49;
   localparam logic [7:0]  PAD_BYTE  = 8'h80;
   localparam logic [7:0]  DBL_POLY  = 8'h87;
   localparam logic [3:0]  LAST_ROUND = 4'd10;

   // configuration register indexes
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic       direction;
   } req_type;

   typedef struct packed {
      logic [31:0] mic_value;
      logic        mic_match;
      logic        length_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUBKEY,
      ST_BLOCK,
      ST_LOAD,
      ST_MIC
   } state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // multiply by x in GF(2^8)
   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes then ShiftRows; byte 0 sits in bits 127:120
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[127 - 8 * (c * 4 + i) -: 8] = SBOX[s[127 - 8 * (((c + i) % 4) * 4 + i) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = s[127 - 32 * c -: 8];
         a1  = s[119 - 32 * c -: 8];
         a2  = s[111 - 32 * c -: 8];
         a3  = s[103 - 32 * c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ all ^ xt(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ all ^ xt(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ all ^ xt(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ all ^ xt(a3 ^ a0);
      end
      return t;
   endfunction

   // next round key from the current one
   function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
      logic [31:0] tmp, w0, w1, w2, w3;
      tmp = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
      w0  = rk[127:96] ^ tmp;
      w1  = rk[95:64] ^ w0;
      w2  = rk[63:32] ^ w1;
      w3  = rk[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // CMAC subkey doubling
   function automatic logic [127:0] dbl(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ {120'h0, (v[127] ? DBL_POLY : 8'h00)};
   endfunction

endpackage

`default_nettype wire

### hdl/fmcv_aes_core.sv
// Iterative AES-128 encryption core, one round per clock with on-the-fly key schedule.
// Depends on fmcv_pkg for the S-box and round functions.
`default_nettype none

module fmcv_aes_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] key,
   input  wire logic [127:0] din,
   output logic              done,
   output logic [127:0]      dout
);

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         run_ff, run_in;
   logic         done_ff, done_in;
   logic [127:0] next_key;
   logic [127:0] shifted;

   // round datapath
   always_comb begin
      next_key = fmcv_pkg::key_step(rkey_ff, rcon_ff);
      shifted  = fmcv_pkg::sub_shift(state_ff);
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start && !run_ff) begin
         state_in = din ^ key;
         rkey_in  = key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         run_in   = 1'b1;
      end else if (run_ff) begin
         rkey_in  = next_key;
         rcon_in  = fmcv_pkg::xt(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == fmcv_pkg::LAST_ROUND) begin
            state_in = shifted ^ next_key;
            run_in   = 1'b0;
            done_in  = 1'b1;
         end else begin
            state_in = fmcv_pkg::mix_columns(shifted) ^ next_key;
         end
      end
   end

   // hold control under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
   end

   assign done = done_ff;
   assign dout = state_ff;

endmodule

`default_nettype wire

### hdl/frame_mic_cmac_verify_unit.sv
// Top level of the frame MIC verify unit: frame store, CMAC sequencer and result register.
// Depends on fmcv_pkg and fmcv_aes_core.
`default_nettype none

// Usage
//   Frame bytes enter one word per cycle on start/req_data while busy is low. The byte
//   with last_byte set closes the frame. The key is written on the csr_ channel
//   (index 0 high half, index 1 low half); the user must write it only while the unit is
//   idle, the unit does not enforce this. Each closed frame gives one result word on
//   rsp_data, marked by rsp_strobe for one cycle; the receiver cannot hold it off.
// Operation
//   Bytes load at one per cycle, while busy is low, into a frame memory with one write
//   port and one read port. A frame that is too short or overflowed answers on the cycle
//   after its last byte and busy stays low. Otherwise busy rises for the CMAC: the
//   subkey, then B0, then per further 16-byte block a sweep of memory reads followed by
//   the iterated AES round unit, then a read-back of the received MIC; the result word
//   follows as busy falls. The AES round unit and the one memory read port pace these steps.
// Reset
//   Synchronous reset clears the byte count, flags and result strobe; the key reads
//   as zero. The frame memory needs no clearing: only bytes of the current frame are read.

module frame_mic_cmac_verify_unit #(
   parameter int unsigned MAX_FRAME = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire fmcv_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output fmcv_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [63:0]      csr_data
);

   localparam int unsigned CW = $clog2(MAX_FRAME + 1);
   localparam int unsigned AW = $clog2(MAX_FRAME);
   localparam int unsigned PW = CW + 1;

   fmcv_pkg::state_type state_ff, state_in;

   logic [63:0]   key_high_ff, key_low_ff;
   logic [7:0]    frame_mem [MAX_FRAME];
   logic [7:0]    mem_q_ff;
   logic [CW-1:0] count_ff, len_ff;
   logic          ovf_ff, dir_ff;
   logic [31:0]   devaddr_ff;
   logic [15:0]   fcnt_ff;
   logic [127:0]  blk_ff, x_ff, k1_ff, k2_ff;
   logic [PW-1:0] base_ff, pos_d_ff;
   logic [4:0]    cnt_ff;
   logic          last_blk_ff;
   logic [31:0]   mic_rx_ff;
   logic          rsp_strobe_ff;
   fmcv_pkg::rsp_type rsp_ff;

   logic          accept, room, err, go;
   logic [CW-1:0] new_count;
   logic          new_ovf, frame_dir;
   logic          aes_start, aes_done;
   logic [127:0]  aes_din, aes_dout, key;
   logic [PW-1:0] rd_pos, len_p, blk_end;
   logic [7:0]    load_byte;
   logic [127:0]  blk_next;
   logic [31:0]   mic_next, computed;
   logic          load_end, mic_end, blk_last;

   assign key       = {key_high_ff, key_low_ff};
   assign busy      = (state_ff != fmcv_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign room      = (count_ff < CW'(MAX_FRAME));
   assign new_count = room ? count_ff + CW'(1) : count_ff;
   assign new_ovf   = ovf_ff || !room;
   assign err       = new_ovf || (new_count < CW'(fmcv_pkg::MIN_FRAME));
   assign go        = accept && req_data.last_byte && !err;
   assign frame_dir = (count_ff == '0 && !ovf_ff) ? req_data.direction : dir_ff;

   assign len_p     = {1'b0, len_ff};
   assign blk_end   = base_ff + PW'(16);
   assign blk_last  = (len_p <= blk_end);
   assign load_end  = (state_ff == fmcv_pkg::ST_LOAD) && (cnt_ff == 5'd16);
   assign mic_end   = (state_ff == fmcv_pkg::ST_MIC) && (cnt_ff == 5'd4);

   // message byte or padding for the delayed read position
   always_comb begin
      if (pos_d_ff < len_p) begin
         load_byte = mem_q_ff;
      end else if (pos_d_ff == len_p) begin
         load_byte = fmcv_pkg::PAD_BYTE;
      end else begin
         load_byte = 8'h00;
      end
   end

   assign blk_next = {blk_ff[119:0], load_byte};
   assign mic_next = {mem_q_ff, mic_rx_ff[31:8]};
   assign computed = {x_ff[103:96], x_ff[111:104], x_ff[119:112], x_ff[127:120]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fmcv_pkg::ST_IDLE: begin
            if (go) begin
               state_in = fmcv_pkg::ST_SUBKEY;
            end
         end
         fmcv_pkg::ST_SUBKEY: begin
            if (aes_done) begin
               state_in = fmcv_pkg::ST_BLOCK;
            end
         end
         fmcv_pkg::ST_BLOCK: begin
            if (aes_done) begin
               state_in = last_blk_ff ? fmcv_pkg::ST_MIC : fmcv_pkg::ST_LOAD;
            end
         end
         fmcv_pkg::ST_LOAD: begin
            if (cnt_ff == 5'd16) begin
               state_in = fmcv_pkg::ST_BLOCK;
            end
         end
         fmcv_pkg::ST_MIC: begin
            if (cnt_ff == 5'd4) begin
               state_in = fmcv_pkg::ST_IDLE;
            end
         end
         default: state_in = fmcv_pkg::ST_IDLE;
      endcase
   end

   // outputs: AES launch and memory read position
   always_comb begin
      aes_start = 1'b0;
      aes_din   = '0;
      rd_pos    = base_ff + PW'(cnt_ff);
      case (state_ff)
         fmcv_pkg::ST_IDLE: begin
            aes_start = go;
         end
         fmcv_pkg::ST_SUBKEY: begin
            aes_start = aes_done;
            aes_din   = blk_ff;
         end
         fmcv_pkg::ST_LOAD: begin
            aes_start = (cnt_ff == 5'd16);
            // mix in a subkey on the final block only
            aes_din   = blk_next ^ x_ff ^
                        (!blk_last ? 128'h0 : ((len_p == blk_end) ? k1_ff : k2_ff));
         end
         fmcv_pkg::ST_MIC: begin
            rd_pos = len_p + PW'(cnt_ff);
         end
         default: begin
            aes_start = 1'b0;
         end
      endcase
   end

   fmcv_aes_core u_aes (
      .clock (clock),
      .reset (reset),
      .start (aes_start),
      .key   (key),
      .din   (aes_din),
      .done  (aes_done),
      .dout  (aes_dout)
   );

   // frame memory: write on accepted bytes while there is room, registered read
   always_ff @(posedge clock) begin
      if (accept && room) begin
         frame_mem[count_ff[AW-1:0]] <= req_data.frame_byte;
      end
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= frame_mem[rd_pos[AW-1:0]];
      pos_d_ff <= rd_pos;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fmcv_pkg::ST_IDLE;
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         dir_ff        <= 1'b0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (accept && req_data.last_byte && err) || mic_end;
         if (csr_valid && csr_ready) begin
            if (csr_index == fmcv_pkg::CSR_KEY_HIGH) begin
               key_high_ff <= csr_data;
            end else begin
               key_low_ff <= csr_data;
            end
         end
         // track the frame being received; drop the frame state at its last byte
         if (accept) begin
            if (req_data.last_byte) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
               dir_ff   <= 1'b0;
            end else begin
               count_ff <= new_count;
               ovf_ff   <= new_ovf;
               dir_ff   <= frame_dir;
            end
         end
         // sweep counter for loads and MIC reads
         if ((state_ff == fmcv_pkg::ST_LOAD && !load_end) ||
             (state_ff == fmcv_pkg::ST_MIC && !mic_end)) begin
            cnt_ff <= cnt_ff + 5'd1;
         end else begin
            cnt_ff <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept && (count_ff inside {[1:4]})) begin
         devaddr_ff <= {devaddr_ff[23:0], req_data.frame_byte};
      end
      if (accept && (count_ff inside {[6:7]})) begin
         fcnt_ff <= {fcnt_ff[7:0], req_data.frame_byte};
      end
      if (go) begin
         len_ff      <= new_count - CW'(fmcv_pkg::MIC_BYTES);
         blk_ff      <= {fmcv_pkg::B0_TAG, 32'h0, 7'h0, frame_dir, devaddr_ff, fcnt_ff,
                         16'h0, 16'(new_count - CW'(fmcv_pkg::MIC_BYTES))};
         x_ff        <= '0;
         base_ff     <= '0;
         last_blk_ff <= 1'b0;
      end
      if (state_ff == fmcv_pkg::ST_SUBKEY && aes_done) begin
         k1_ff <= fmcv_pkg::dbl(aes_dout);
         k2_ff <= fmcv_pkg::dbl(fmcv_pkg::dbl(aes_dout));
      end
      if (state_ff == fmcv_pkg::ST_BLOCK && aes_done) begin
         x_ff <= aes_dout;
      end
      if (state_ff == fmcv_pkg::ST_LOAD && cnt_ff != 5'd0) begin
         blk_ff <= blk_next;
      end
      if (load_end) begin
         base_ff     <= blk_end;
         last_blk_ff <= blk_last;
      end
      if (state_ff == fmcv_pkg::ST_MIC && cnt_ff != 5'd0) begin
         mic_rx_ff <= mic_next;
      end
      // result word
      if (accept && req_data.last_byte && err) begin
         rsp_ff <= '{mic_value: 32'h0, mic_match: 1'b0, length_error: 1'b1};
      end else if (mic_end) begin
         rsp_ff <= '{mic_value: computed, mic_match: (computed == mic_next),
                     length_error: 1'b0};
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

### hdl/fmcv_checker.sv
// Port-level checks for the frame MIC verify unit, bound to its top level.
// Depends on fmcv_pkg and frame_mic_cmac_verify_unit.
`default_nettype none

module fmcv_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire fmcv_pkg::req_type req_data,
   input wire logic              rsp_strobe,
   input wire fmcv_pkg::rsp_type rsp_data
);

   // an error word carries no MIC
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.length_error |-> rsp_data.mic_value == 32'h0 && !rsp_data.mic_match)
      else $error("error word carries a MIC");

   // CMAC work starts only from a last byte
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) && !$past(reset) |-> $past(start) && $past(req_data.last_byte))
      else $error("busy without a closing word");

   // end of CMAC work delivers a checked word
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe && !rsp_data.length_error)
      else $error("CMAC finished without a result word");

   // error words follow an accepted last byte directly
   a_err_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.length_error && !$past(reset) |->
         $past(start) && !$past(busy) && $past(req_data.last_byte))
      else $error("error word without a closing word");

   // reset leaves the unit idle and silent
   a_reset: assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("activity after reset");

endmodule

bind frame_mic_cmac_verify_unit fmcv_checker u_fmcv_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
